@@ rtl/core/mtep_pkg.sv @@
// Shared types, codes and the helper function of the MIDI track event parser.
package mtep_pkg;

  localparam int TICK_BITS = 40;
  localparam int TICK_W = 40;
  localparam int VLQ_W = 28;
  localparam int TEMPO_W = 24;

  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [3:0] ERR_NONE = 4'd0;
  localparam logic [3:0] ERR_TRUNCATED = 4'd1;
  localparam logic [3:0] ERR_VLQ_LONG = 4'd2;
  localparam logic [3:0] ERR_BAD_STATUS = 4'd3;
  localparam logic [3:0] ERR_NO_RUNNING = 4'd4;
  localparam logic [3:0] ERR_BAD_DATA = 4'd5;
  localparam logic [3:0] ERR_BAD_EOT = 4'd6;
  localparam logic [3:0] ERR_TEMPO_LEN = 4'd7;
  localparam logic [3:0] ERR_TEMPO_ZERO = 4'd8;
  localparam logic [3:0] ERR_LEN_MISMATCH = 4'd9;
  localparam logic [3:0] ERR_TICK_OVERFLOW = 4'd10;

  localparam logic [7:0] ST_META = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] META_EOT = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON = 4'h9;

  localparam logic [1:0] APB_ADDR_TRACK = 2'd0;

  typedef enum logic [3:0] {
    PH_DELTA = 4'd0,
    PH_STATUS = 4'd1,
    PH_DATA1 = 4'd2,
    PH_DATA2 = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN = 4'd5,
    PH_SYSEX_LEN = 4'd6,
    PH_TEMPO = 4'd7,
    PH_SKIP = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_ONE = 2'd1,
    LEN_TWO = 2'd2
  } msg_len_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [TICK_W-1:0] tick;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [TEMPO_W-1:0] tempo_period;
    logic [3:0] error_code;
    logic last;
  } result_t;

  typedef struct packed {
    logic v0;
    logic v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic msg_len_t data_len(input logic [7:0] st);
    msg_len_t len;
    begin
      unique case (st[7:4])
        4'hC, 4'hD: len = LEN_ONE;
        4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_TWO;
        default: len = LEN_NONE;
      endcase
      return len;
    end
  endfunction

endpackage

@@ rtl/core/mtep_parser.sv @@
// Parse state registers and the per-beat decode of one track byte.
module mtep_parser
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       track_start,
  input  logic       track_last,
  output push_t      push
);

  phase_t phase, phase_next, c_phase;
  logic [TICK_BITS-1:0] abs_tick, abs_tick_next, c_tick;
  logic [7:0] running_status, running_status_next, c_rs;
  logic [VLQ_W-1:0] vlq_value, vlq_value_next, c_vlq;
  logic [1:0] vlq_bytes, vlq_bytes_next, c_vlqb;
  logic [VLQ_W-1:0] skip_remaining, skip_remaining_next, c_skip;
  logic [7:0] meta_kind, meta_kind_next, c_meta;
  logic [TEMPO_W-1:0] tempo_accum, tempo_accum_next, c_tacc;
  logic [1:0] tempo_bytes, tempo_bytes_next, c_tbytes;
  logic [7:0] held_status, held_status_next, c_hs;
  logic [7:0] held_data1, held_data1_next, c_hd1;
  logic halted, halted_next, c_halted;

  logic [VLQ_W-1:0] vlq_new;
  logic [TICK_BITS:0] tick_sum;
  logic [TEMPO_W-1:0] tempo_new;
  logic [1:0] tbytes_inc;

  logic ev_fail, ev_fin, ev_tempo, ev_end, tail_end, tail_fail;
  logic [3:0] ev_code;
  logic [7:0] fin_st, fin_d1, fin_d2;

  logic [7:0] norm_d2, norm_st;
  logic main_v, tail_v;
  result_t main_res, tail_res;

  always_comb begin
    c_phase = track_start ? PH_DELTA : phase;
    c_tick = track_start ? '0 : abs_tick;
    c_rs = track_start ? 8'h00 : running_status;
    c_vlq = track_start ? '0 : vlq_value;
    c_vlqb = track_start ? 2'd0 : vlq_bytes;
    c_skip = track_start ? '0 : skip_remaining;
    c_meta = track_start ? 8'h00 : meta_kind;
    c_tacc = track_start ? '0 : tempo_accum;
    c_tbytes = track_start ? 2'd0 : tempo_bytes;
    c_hs = track_start ? 8'h00 : held_status;
    c_hd1 = track_start ? 8'h00 : held_data1;
    c_halted = track_start ? 1'b0 : halted;
  end

  assign vlq_new = {c_vlq[VLQ_W-8:0], data_byte[6:0]};
  assign tick_sum = {1'b0, c_tick} + (TICK_BITS + 1)'(vlq_new);
  assign tempo_new = {c_tacc[TEMPO_W-9:0], data_byte};
  assign tbytes_inc = c_tbytes + 2'd1;

  // Next state of the parse phase and of the datapath registers.
  always_comb begin
    phase_next = c_phase;
    abs_tick_next = c_tick;
    running_status_next = c_rs;
    vlq_value_next = c_vlq;
    vlq_bytes_next = c_vlqb;
    skip_remaining_next = c_skip;
    meta_kind_next = c_meta;
    tempo_accum_next = c_tacc;
    tempo_bytes_next = c_tbytes;
    held_status_next = c_hs;
    held_data1_next = c_hd1;
    halted_next = c_halted;
    ev_fail = 1'b0;
    ev_code = ERR_NONE;
    ev_fin = 1'b0;
    ev_tempo = 1'b0;
    ev_end = 1'b0;
    tail_end = 1'b0;
    tail_fail = 1'b0;
    fin_st = c_hs;
    fin_d1 = c_hd1;
    fin_d2 = 8'h00;
    if (!c_halted) begin
      unique case (c_phase)
        PH_DELTA: begin
          if (!data_byte[7]) begin
            vlq_bytes_next = 2'd0;
            vlq_value_next = '0;
            if (tick_sum[TICK_BITS]) begin
              ev_fail = 1'b1;
              ev_code = ERR_TICK_OVERFLOW;
            end else begin
              abs_tick_next = tick_sum[TICK_BITS-1:0];
              phase_next = PH_STATUS;
            end
          end else begin
            vlq_value_next = vlq_new;
            if (c_vlqb == 2'd3) begin
              ev_fail = 1'b1;
              ev_code = ERR_VLQ_LONG;
            end else begin
              vlq_bytes_next = c_vlqb + 2'd1;
            end
          end
        end
        PH_STATUS: begin
          if (data_byte == ST_META) begin
            running_status_next = 8'h00;
            phase_next = PH_META_TYPE;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_CONT) begin
            running_status_next = 8'h00;
            phase_next = PH_SYSEX_LEN;
          end else if (data_byte[7]) begin
            if (data_len(data_byte) == LEN_NONE) begin
              ev_fail = 1'b1;
              ev_code = ERR_BAD_STATUS;
            end else begin
              running_status_next = data_byte;
              held_status_next = data_byte;
              phase_next = PH_DATA1;
            end
          end else if (c_rs == 8'h00) begin
            ev_fail = 1'b1;
            ev_code = ERR_NO_RUNNING;
          end else begin
            held_status_next = c_rs;
            held_data1_next = data_byte;
            if (data_len(c_rs) == LEN_TWO) begin
              phase_next = PH_DATA2;
            end else begin
              ev_fin = 1'b1;
              fin_st = c_rs;
              fin_d1 = data_byte;
            end
          end
        end
        PH_DATA1: begin
          held_data1_next = data_byte;
          if (data_len(c_hs) == LEN_TWO) begin
            phase_next = PH_DATA2;
          end else begin
            ev_fin = 1'b1;
            fin_d1 = data_byte;
          end
        end
        PH_DATA2: begin
          ev_fin = 1'b1;
          fin_d2 = data_byte;
        end
        PH_META_TYPE: begin
          meta_kind_next = data_byte;
          phase_next = PH_META_LEN;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          if (!data_byte[7]) begin
            vlq_bytes_next = 2'd0;
            vlq_value_next = '0;
            if (c_phase == PH_META_LEN && c_meta == META_EOT) begin
              if (vlq_new != '0) begin
                ev_fail = 1'b1;
                ev_code = ERR_BAD_EOT;
              end else if (!track_last) begin
                ev_fail = 1'b1;
                ev_code = ERR_LEN_MISMATCH;
              end else begin
                ev_end = 1'b1;
              end
            end else if (c_phase == PH_META_LEN && c_meta == META_TEMPO) begin
              if (vlq_new != VLQ_W'(3)) begin
                ev_fail = 1'b1;
                ev_code = ERR_TEMPO_LEN;
              end else begin
                tempo_accum_next = '0;
                tempo_bytes_next = 2'd0;
                phase_next = PH_TEMPO;
              end
            end else begin
              skip_remaining_next = vlq_new;
              phase_next = (vlq_new == '0) ? PH_DELTA : PH_SKIP;
            end
          end else begin
            vlq_value_next = vlq_new;
            if (c_vlqb == 2'd3) begin
              ev_fail = 1'b1;
              ev_code = ERR_VLQ_LONG;
            end else begin
              vlq_bytes_next = c_vlqb + 2'd1;
            end
          end
        end
        PH_TEMPO: begin
          tempo_accum_next = tempo_new;
          tempo_bytes_next = tbytes_inc;
          if (tbytes_inc == 2'd3) begin
            tempo_bytes_next = 2'd0;
            if (tempo_new == '0) begin
              ev_fail = 1'b1;
              ev_code = ERR_TEMPO_ZERO;
            end else begin
              ev_tempo = 1'b1;
              phase_next = PH_DELTA;
            end
          end
        end
        PH_SKIP: begin
          if (c_skip != '0) begin
            skip_remaining_next = c_skip - VLQ_W'(1);
          end
          if (c_skip <= VLQ_W'(1)) begin
            phase_next = PH_DELTA;
          end
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase

      if (ev_fin) begin
        if (fin_d1[7] || (data_len(fin_st) == LEN_TWO && fin_d2[7])) begin
          ev_fin = 1'b0;
          ev_fail = 1'b1;
          ev_code = ERR_BAD_DATA;
        end else begin
          phase_next = PH_DELTA;
        end
      end
      if (ev_fail || ev_end) begin
        halted_next = 1'b1;
      end
      if (!halted_next && track_last) begin
        halted_next = 1'b1;
        if (phase_next == PH_DELTA && vlq_bytes_next == 2'd0) begin
          tail_end = 1'b1;
        end else begin
          tail_fail = 1'b1;
        end
      end
    end
  end

  // Result beats of this byte.
  always_comb begin
    norm_d2 = (data_len(fin_st) == LEN_TWO) ? fin_d2 : 8'h00;
    norm_st = fin_st;
    if (fin_st[7:4] == NIB_NOTE_ON && norm_d2 == 8'h00) begin
      norm_st = {NIB_NOTE_OFF, fin_st[3:0]};
    end
    main_v = ev_fail || ev_fin || ev_tempo || ev_end;
    tail_v = tail_end || tail_fail;

    main_res = '0;
    main_res.tick = TICK_W'(abs_tick_next);
    if (ev_fail) begin
      main_res.kind = KIND_ERROR;
      main_res.error_code = ev_code;
    end else if (ev_fin) begin
      main_res.kind = KIND_CHANNEL;
      main_res.status = norm_st;
      main_res.data1 = fin_d1[6:0];
      main_res.data2 = norm_d2[6:0];
    end else if (ev_tempo) begin
      main_res.kind = KIND_TEMPO;
      main_res.tempo_period = tempo_new;
    end else begin
      main_res.kind = KIND_END;
    end

    tail_res = '0;
    tail_res.tick = TICK_W'(abs_tick_next);
    tail_res.kind = tail_fail ? KIND_ERROR : KIND_END;
    tail_res.error_code = tail_fail ? ERR_TRUNCATED : ERR_NONE;
    tail_res.last = 1'b1;

    push.v0 = step_en && (main_v || tail_v);
    push.v1 = step_en && main_v && tail_v;
    push.r0 = main_v ? main_res : tail_res;
    push.r0.last = !(main_v && tail_v);
    push.r1 = tail_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA;
      abs_tick <= '0;
      running_status <= 8'h00;
      vlq_value <= '0;
      vlq_bytes <= 2'd0;
      skip_remaining <= '0;
      meta_kind <= 8'h00;
      tempo_accum <= '0;
      tempo_bytes <= 2'd0;
      held_status <= 8'h00;
      held_data1 <= 8'h00;
      halted <= 1'b0;
    end else if (step_en) begin
      phase <= phase_next;
      abs_tick <= abs_tick_next;
      running_status <= running_status_next;
      vlq_value <= vlq_value_next;
      vlq_bytes <= vlq_bytes_next;
      skip_remaining <= skip_remaining_next;
      meta_kind <= meta_kind_next;
      tempo_accum <= tempo_accum_next;
      tempo_bytes <= tempo_bytes_next;
      held_status <= held_status_next;
      held_data1 <= held_data1_next;
      halted <= halted_next;
    end
  end

endmodule

@@ rtl/core/mtep_out_queue.sv @@
// Result queue that takes up to two beats per cycle and hands out one.
module mtep_out_queue
  import mtep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              pop,
  output result_t           head,
  output logic              head_valid,
  output logic [QCNT_W-1:0] count
);

  result_t entries [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr, rd_ptr;
  logic [QIDX_W-1:0] wr_ptr_next;
  logic [QCNT_W-1:0] count_next;

  always_comb begin
    wr_ptr_next = wr_ptr + QIDX_W'(push.v0) + QIDX_W'(push.v1);
    count_next = count + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wr_ptr + QIDX_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QIDX_W'(1);
      end
    end
  end

  assign head = entries[rd_ptr];
  assign head_valid = (count != '0);

endmodule

@@ rtl/core/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: input stage, register port and result queue.
//
// Bytes of a track chunk enter on the input channel (in_valid, in_stall, data_byte,
// track_start, track_last). Each accepted beat is held in an input register and decoded
// from there once the queue has room for two beats; this updates the parse state and
// writes zero, one or two result beats into a four-entry result queue. The output
// channel (out_valid, out_stall and the result fields) is driven straight from the head of that queue.
// A result passes the input register and the queue before it is shown on out_valid.
// One byte is taken per cycle as long as each byte gives at most one result and the
// receiver does not stall; the single output beat per cycle sets the rate, so a byte that
// gives two results can hold the input back when the queue backs up.
// When the receiver stalls, results collect in the queue, and in_stall rises once the
// queue has no room left for the two beats that one byte may give.
// The track_number register sits at address 0 of the register port and is copied into
// every result. The user must write it only while the block is idle; the block does not enforce this.
// Reset clears the parse state, the queue and the register; there is no clearing pass.
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 track_start,
  input  logic                 track_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [TICK_W-1:0]    tick,
  output logic [15:0]          track,
  output logic [7:0]           status,
  output logic [6:0]           data1,
  output logic [6:0]           data2,
  output logic [TEMPO_W-1:0]   tempo_period,
  output logic [3:0]           error_code,
  output logic                 last
);

  logic [15:0] track_number;
  logic in_q_valid;
  logic [7:0] in_q_byte;
  logic in_q_start;
  logic in_q_last;
  logic step_en;
  logic in_accept;
  logic pop;
  push_t push;
  result_t head;
  logic head_valid;
  logic [QCNT_W-1:0] count;

  assign pready = 1'b1;
  assign prdata = (paddr == APB_ADDR_TRACK) ? {16'h0000, track_number} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_number <= 16'h0000;
    end else if (psel && penable && pwrite && pready && paddr == APB_ADDR_TRACK) begin
      track_number <= pwdata[15:0];
    end
  end

  assign step_en = in_q_valid && (count <= QCNT_W'(QDEPTH - 2));
  assign in_stall = in_q_valid && !step_en;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (step_en) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_byte <= data_byte;
      in_q_start <= track_start;
      in_q_last <= track_last;
    end
  end

  mtep_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .data_byte  (in_q_byte),
    .track_start(in_q_start),
    .track_last (in_q_last),
    .push       (push)
  );

  assign pop = head_valid && !out_stall;

  mtep_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .count     (count)
  );

  assign out_valid = head_valid;
  assign kind = head.kind;
  assign tick = head.tick;
  assign track = track_number;
  assign status = head.status;
  assign data1 = head.data1;
  assign data2 = head.data2;
  assign tempo_period = head.tempo_period;
  assign error_code = head.error_code;
  assign last = head.last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("Result queue holds more beats than it has entries.");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && !push.r0.last && push.r1.last))
    else $error("A second result beat was pushed without a proper first beat.");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (rst)
    (count > QCNT_W'(QDEPTH - 2)) |-> !push.v0)
    else $error("A byte was decoded while the result queue lacked room.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Results are shown right after reset.");
`endif

endmodule
